@@ src/rpsh_pkg.sv @@
// rpsh_pkg: types, codes and reset constants for the radio pairing slave handshake
// no dependencies; imported by every other file of the block

package rpsh_pkg;

  // field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned MAGIC_W = 8;
  localparam int unsigned ADDR_W  = 40;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned WAIT_W  = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 40;

  // commands
  localparam logic [CMD_W-1:0] CMD_STEP  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

  // received packet kinds
  localparam logic [KIND_W-1:0] RX_OTHER = 2'd0;
  localparam logic [KIND_W-1:0] RX_RESP  = 2'd1;
  localparam logic [KIND_W-1:0] RX_PING  = 2'd2;

  // transmitted packet kinds
  localparam logic TX_REQ  = 1'b0;
  localparam logic TX_PONG = 1'b1;

  // reported phase codes
  localparam logic [PHASE_W-1:0] PH_CODE_IDLE   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_CODE_SEND   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_CODE_WAIT   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_CODE_VERIFY = 3'd3;
  localparam logic [PHASE_W-1:0] PH_CODE_DONE   = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_TIMEOUT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESP_WAIT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VERIFY_TIMEOUT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VERIFY_NEEDED  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAGIC      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PEER_MAGIC     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ADDR   = 3'd6;

  // configuration reset values
  localparam logic [TIME_W-1:0]  RST_GLOBAL_TIMEOUT = 32'd10000;
  localparam logic [WAIT_W-1:0]  RST_RESP_WAIT      = 16'd200;
  localparam logic [WAIT_W-1:0]  RST_VERIFY_TIMEOUT = 16'd2000;
  localparam logic [CNT_W-1:0]   RST_VERIFY_NEEDED  = 8'd5;
  localparam logic [MAGIC_W-1:0] RST_OWN_MAGIC      = 8'h5A;
  localparam logic [MAGIC_W-1:0] RST_PEER_MAGIC     = 8'hA5;
  localparam logic [ADDR_W-1:0]  RST_DEFAULT_ADDR   = 40'hEE_DDCC_BBAA;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // pairing phase, one-hot
  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_SEND   = 5'b00010,
    PH_WAIT   = 5'b00100,
    PH_VERIFY = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [TIME_W-1:0]  session_timeout_ms;
    logic [WAIT_W-1:0]  resp_wait_ms;
    logic [WAIT_W-1:0]  verify_timeout_ms;
    logic [CNT_W-1:0]   verify_needed;
    logic [MAGIC_W-1:0] own_magic;
    logic [MAGIC_W-1:0] peer_magic;
    logic [ADDR_W-1:0]  default_addr;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [TIME_W-1:0]  now_ms;
    logic               rx_valid;
    logic               rx_len_ok;
    logic [KIND_W-1:0]  rx_kind;
    logic [MAGIC_W-1:0] rx_magic;
    logic [ADDR_W-1:0]  rx_addr;
  } in_item_t;

  typedef struct packed {
    logic               tx_valid;
    logic               tx_kind;
    logic               addr_valid;
    logic [ADDR_W-1:0]  addr_value;
    logic [PHASE_W-1:0] phase;
    logic               running;
    logic [CNT_W-1:0]   verified;
  } out_item_t;

  // one-hot phase to reported code
  function automatic logic [PHASE_W-1:0] phase_code(phase_t ph);
    logic [PHASE_W-1:0] code;
    case (ph)
      PH_IDLE:   code = PH_CODE_IDLE;
      PH_SEND:   code = PH_CODE_SEND;
      PH_WAIT:   code = PH_CODE_WAIT;
      PH_VERIFY: code = PH_CODE_VERIFY;
      PH_DONE:   code = PH_CODE_DONE;
      default:   code = PH_CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

@@ src/rpsh_if.sv @@
// rpsh_in_if / rpsh_out_if: valid/ready channels for step requests and results
// depends on rpsh_pkg for field widths

interface rpsh_in_if import rpsh_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [TIME_W-1:0]  now_ms;
  logic               rx_valid;
  logic               rx_len_ok;
  logic [KIND_W-1:0]  rx_kind;
  logic [MAGIC_W-1:0] rx_magic;
  logic [ADDR_W-1:0]  rx_addr;

  modport source (
    output valid, cmd, now_ms, rx_valid, rx_len_ok, rx_kind, rx_magic, rx_addr,
    input  ready
  );
  modport sink (
    input  valid, cmd, now_ms, rx_valid, rx_len_ok, rx_kind, rx_magic, rx_addr,
    output ready
  );
endinterface

interface rpsh_out_if import rpsh_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               tx_valid;
  logic               tx_kind;
  logic               addr_valid;
  logic [ADDR_W-1:0]  addr_value;
  logic [PHASE_W-1:0] phase;
  logic               running;
  logic [CNT_W-1:0]   verified;

  modport source (
    output valid, tx_valid, tx_kind, addr_valid, addr_value, phase, running, verified,
    input  ready
  );
  modport sink (
    input  valid, tx_valid, tx_kind, addr_valid, addr_value, phase, running, verified,
    output ready
  );
endinterface

@@ src/radio_pairing_slave_handshake_unit.sv @@
// radio_pairing_slave_handshake_unit: top level of the pairing slave handshake
// depends on rpsh_pkg, rpsh_if, rpsh_cfg_regs, rpsh_in_stage and rpsh_core
//
// Usage:
//   in_ch carries one step request per handshake: a command (service, start,
//   stop), the current ms time and an optional pre-classified received packet.
//   out_ch returns exactly one result per request: packet to send, address to
//   program, and the phase, running flag and ping count after the step.
//   cfg_we/cfg_idx/cfg_wdata write the seven settings; write only while idle.
// Flow:
//   a request accepted on in_ch is captured in the input register; when the
//   result register is free it updates the pairing state and is loaded
//   into the result register at the same edge. One request is taken
//   every cycle unless out_ch stalls: the state update is one combinational
//   pass of two 32-bit subtractions, three compares and a phase decode.
// Reset:
//   rst_n low clears the pairing state (phase idle, not running, counters and
//   timestamps zero), empties both stages and restores the settings defaults.
// Stall:
//   while out_ch.ready is low the result holds; the input register keeps one
//   more request, after which in_ch.ready drops until the result is taken.

module radio_pairing_slave_handshake_unit import rpsh_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  rpsh_in_if.sink               in_ch,
  rpsh_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t      cfg;
  in_item_t  in_item;
  in_item_t  hold_item;
  logic      hold_valid;
  logic      advance;
  out_item_t result;
  out_item_t out_item_r;
  logic      out_valid_r;
  logic      out_valid_nxt;

  // gather channel fields
  assign in_item.cmd       = in_ch.cmd;
  assign in_item.now_ms    = in_ch.now_ms;
  assign in_item.rx_valid  = in_ch.rx_valid;
  assign in_item.rx_len_ok = in_ch.rx_len_ok;
  assign in_item.rx_kind   = in_ch.rx_kind;
  assign in_item.rx_magic  = in_ch.rx_magic;
  assign in_item.rx_addr   = in_ch.rx_addr;

  rpsh_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rpsh_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_item),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  // held request moves when the result register is free
  assign advance = hold_valid && (!out_valid_r || out_ch.ready);

  rpsh_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .advance(advance),
    .item   (hold_item),
    .cfg    (cfg),
    .result (result)
  );

  // result register
  assign out_valid_nxt = advance || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.tx_valid   = out_item_r.tx_valid;
  assign out_ch.tx_kind    = out_item_r.tx_kind;
  assign out_ch.addr_valid = out_item_r.addr_valid;
  assign out_ch.addr_value = out_item_r.addr_value;
  assign out_ch.phase      = out_item_r.phase;
  assign out_ch.running    = out_item_r.running;
  assign out_ch.verified   = out_item_r.verified;

endmodule

@@ src/rpsh_cfg_regs.sv @@
// rpsh_cfg_regs: configuration register file with plain write port
// depends on rpsh_pkg for register indexes and reset values

module rpsh_cfg_regs import rpsh_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // decode write, writes beyond the list are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_GLOBAL_TIMEOUT: cfg_nxt.session_timeout_ms = cfg_wdata[TIME_W-1:0];
        CFG_RESP_WAIT:      cfg_nxt.resp_wait_ms       = cfg_wdata[WAIT_W-1:0];
        CFG_VERIFY_TIMEOUT: cfg_nxt.verify_timeout_ms  = cfg_wdata[WAIT_W-1:0];
        CFG_VERIFY_NEEDED:  cfg_nxt.verify_needed      = cfg_wdata[CNT_W-1:0];
        CFG_OWN_MAGIC:      cfg_nxt.own_magic          = cfg_wdata[MAGIC_W-1:0];
        CFG_PEER_MAGIC:     cfg_nxt.peer_magic         = cfg_wdata[MAGIC_W-1:0];
        CFG_DEFAULT_ADDR:   cfg_nxt.default_addr       = cfg_wdata[ADDR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.session_timeout_ms <= RST_GLOBAL_TIMEOUT;
      cfg_r.resp_wait_ms       <= RST_RESP_WAIT;
      cfg_r.verify_timeout_ms  <= RST_VERIFY_TIMEOUT;
      cfg_r.verify_needed      <= RST_VERIFY_NEEDED;
      cfg_r.own_magic          <= RST_OWN_MAGIC;
      cfg_r.peer_magic         <= RST_PEER_MAGIC;
      cfg_r.default_addr       <= RST_DEFAULT_ADDR;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ src/rpsh_in_stage.sv @@
// rpsh_in_stage: input register holding one step request until the core takes it
// depends on rpsh_pkg for the request struct

module rpsh_in_stage import rpsh_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     advance,
  output logic     hold_valid,
  output in_item_t hold_item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  // free when empty or when the held request moves on this cycle
  assign in_ready  = !valid_r || advance;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign hold_valid = valid_r;
  assign hold_item  = item_r;

endmodule

@@ src/rpsh_core.sv @@
// rpsh_core: pairing state registers and the per-request update logic
// depends on rpsh_pkg for phase type, codes and structs

module rpsh_core import rpsh_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      advance,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  phase_t            phase_r, phase_nxt;
  logic              active_r, active_nxt;
  logic [TIME_W-1:0] global_start_r, global_start_nxt;
  logic [TIME_W-1:0] wait_start_r, wait_start_nxt;
  logic [CNT_W-1:0]  ping_r, ping_nxt;

  logic [TIME_W-1:0] global_elapsed;
  logic [TIME_W-1:0] wait_elapsed;
  logic              global_expired;
  logic              resp_expired;
  logic              verify_expired;
  logic              resp_ok;
  logic              ping_ok;
  logic [CNT_W-1:0]  ping_inc;

  // elapsed times on wrapping ms counter
  assign global_elapsed = item.now_ms - global_start_r;
  assign wait_elapsed   = item.now_ms - wait_start_r;
  assign global_expired = global_elapsed > cfg.session_timeout_ms;
  assign resp_expired   = wait_elapsed > {{(TIME_W-WAIT_W){1'b0}}, cfg.resp_wait_ms};
  assign verify_expired = wait_elapsed > {{(TIME_W-WAIT_W){1'b0}}, cfg.verify_timeout_ms};

  // packet qualification
  assign resp_ok = item.rx_valid && item.rx_len_ok && (item.rx_kind == RX_RESP);
  assign ping_ok = item.rx_valid && item.rx_len_ok && (item.rx_kind == RX_PING)
                   && (item.rx_magic == cfg.peer_magic);
  assign ping_inc = (ping_r != CNT_MAX) ? ping_r + 1'b1 : ping_r;

  // next state and packet decisions
  always_comb begin
    phase_nxt         = phase_r;
    active_nxt        = active_r;
    global_start_nxt  = global_start_r;
    wait_start_nxt    = wait_start_r;
    ping_nxt          = ping_r;
    result            = '0;

    case (item.cmd)
      CMD_START: begin
        phase_nxt         = PH_IDLE;
        active_nxt        = 1'b1;
        global_start_nxt  = item.now_ms;
        wait_start_nxt    = '0;
        ping_nxt          = '0;
        result.addr_valid = 1'b1;
        result.addr_value = cfg.default_addr;
      end
      CMD_STOP: begin
        if (active_r) begin
          active_nxt = 1'b0;
          phase_nxt  = PH_IDLE;
        end
      end
      CMD_STEP: begin
        if (active_r) begin
          if (global_expired) begin
            // global timeout restarts pairing like a start
            phase_nxt         = PH_IDLE;
            global_start_nxt  = item.now_ms;
            wait_start_nxt    = '0;
            ping_nxt          = '0;
            result.addr_valid = 1'b1;
            result.addr_value = cfg.default_addr;
          end else begin
            case (phase_r)
              PH_SEND: begin
                result.addr_valid = 1'b1;
                result.addr_value = cfg.default_addr;
                result.tx_valid   = 1'b1;
                result.tx_kind    = TX_REQ;
                wait_start_nxt    = item.now_ms;
                phase_nxt         = PH_WAIT;
              end
              PH_WAIT: begin
                if (resp_ok) begin
                  result.addr_valid = 1'b1;
                  result.addr_value = item.rx_addr;
                  ping_nxt          = '0;
                  wait_start_nxt    = item.now_ms;
                  phase_nxt         = PH_VERIFY;
                end else if (resp_expired) begin
                  phase_nxt = PH_SEND;
                end
              end
              PH_VERIFY: begin
                if (ping_ok) begin
                  result.tx_valid = 1'b1;
                  result.tx_kind  = TX_PONG;
                  ping_nxt        = ping_inc;
                  if (ping_inc >= cfg.verify_needed) begin
                    phase_nxt = PH_DONE;
                  end
                end
                // verify timeout wins over a just-reached done
                if (verify_expired) begin
                  phase_nxt = PH_SEND;
                end
              end
              PH_DONE: begin
                active_nxt = 1'b0;
              end
              PH_IDLE: begin
                phase_nxt = PH_SEND;
              end
              default: begin
                phase_nxt = PH_SEND;
              end
            endcase
          end
        end
      end
      default: begin
      end
    endcase

    result.phase    = phase_code(phase_nxt);
    result.running  = active_nxt;
    result.verified = ping_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      active_r       <= 1'b0;
      global_start_r <= '0;
      wait_start_r   <= '0;
      ping_r         <= '0;
    end else if (advance) begin
      phase_r        <= phase_nxt;
      active_r       <= active_nxt;
      global_start_r <= global_start_nxt;
      wait_start_r   <= wait_start_nxt;
      ping_r         <= ping_nxt;
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// tb_top: self-checking bench for radio_pairing_slave_handshake_unit, one status check per step
// depends on rpsh_pkg, the rpsh_in_if / rpsh_out_if channels and the unit itself

module tb_top;
  import rpsh_pkg::*;

  // command code the unit must ignore
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef enum int {PKT_NONE, PKT_RESP, PKT_PING, PKT_JUNK} pkt_sel_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  rpsh_in_if  in_ch ();
  rpsh_out_if out_ch ();

  radio_pairing_slave_handshake_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // request traffic and predicted status
  in_item_t  step_requests[$];
  out_item_t pairing_status_q[$];
  in_item_t  on_bus;
  logic [TIME_W-1:0] sched_ms;

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_go;
  bit hold_on;
  int fail_count;

  // shadow of the pairing state and settings
  cfg_t               pair_cfg;
  logic [PHASE_W-1:0] pr_phase;
  logic               pr_active;
  logic [TIME_W-1:0]  pr_global_start;
  logic [TIME_W-1:0]  pr_wait_start;
  logic [CNT_W-1:0]   pr_pings;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // restart the shadow pairing state: idle, running, counters cleared, session start at now
  function automatic void pairing_restart(input logic [TIME_W-1:0] now);
    pr_phase        = PH_CODE_IDLE;
    pr_active       = 1'b1;
    pr_global_start = now;
    pr_wait_start   = '0;
    pr_pings        = '0;
  endfunction

  // advance the shadow state by one request, return the status it reports
  function automatic out_item_t pairing_step(input in_item_t rq);
    out_item_t res;
    logic [TIME_W-1:0] since_start;
    logic [TIME_W-1:0] since_wait;
    res         = '0;
    since_start = rq.now_ms - pr_global_start;
    since_wait  = rq.now_ms - pr_wait_start;
    if (rq.cmd == CMD_START) begin
      pairing_restart(rq.now_ms);
      res.addr_valid = 1'b1;
      res.addr_value = pair_cfg.default_addr;
    end else if (rq.cmd == CMD_STOP) begin
      if (pr_active) begin
        pr_active = 1'b0;
        pr_phase  = PH_CODE_IDLE;
      end
    end else if (rq.cmd == CMD_STEP && pr_active) begin
      if (since_start > pair_cfg.session_timeout_ms) begin
        pairing_restart(rq.now_ms);
        res.addr_valid = 1'b1;
        res.addr_value = pair_cfg.default_addr;
      end else begin
        case (pr_phase)
          PH_CODE_SEND: begin
            res.addr_valid = 1'b1;
            res.addr_value = pair_cfg.default_addr;
            res.tx_valid   = 1'b1;
            res.tx_kind    = TX_REQ;
            pr_wait_start  = rq.now_ms;
            pr_phase       = PH_CODE_WAIT;
          end
          PH_CODE_WAIT: begin
            if (rq.rx_valid && rq.rx_len_ok && rq.rx_kind == RX_RESP) begin
              res.addr_valid = 1'b1;
              res.addr_value = rq.rx_addr;
              pr_pings       = '0;
              pr_wait_start  = rq.now_ms;
              pr_phase       = PH_CODE_VERIFY;
            end else if (since_wait > pair_cfg.resp_wait_ms) begin
              pr_phase = PH_CODE_SEND;
            end
          end
          PH_CODE_VERIFY: begin
            if (rq.rx_valid && rq.rx_len_ok && rq.rx_kind == RX_PING &&
                rq.rx_magic == pair_cfg.peer_magic) begin
              res.tx_valid = 1'b1;
              res.tx_kind  = TX_PONG;
              if (pr_pings != CNT_MAX) pr_pings = pr_pings + 1'b1;
              if (pr_pings >= pair_cfg.verify_needed) pr_phase = PH_CODE_DONE;
            end
            // verify timeout wins over a just-reached done
            if (since_wait > pair_cfg.verify_timeout_ms) pr_phase = PH_CODE_SEND;
          end
          PH_CODE_DONE: pr_active = 1'b0;
          default:      pr_phase = PH_CODE_SEND;
        endcase
      end
    end
    res.phase    = pr_phase;
    res.running  = pr_active;
    res.verified = pr_pings;
    return res;
  endfunction

  // request driver
  always @(posedge clk) begin : step_driver
    in_item_t rq;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) pairing_status_q.push_back(pairing_step(on_bus));
      if (!in_ch.valid || in_ch.ready) begin
        if (step_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          rq = step_requests.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.cmd       <= rq.cmd;
          in_ch.now_ms    <= rq.now_ms;
          in_ch.rx_valid  <= rq.rx_valid;
          in_ch.rx_len_ok <= rq.rx_len_ok;
          in_ch.rx_kind   <= rq.rx_kind;
          in_ch.rx_magic  <= rq.rx_magic;
          in_ch.rx_addr   <= rq.rx_addr;
          on_bus          <= rq;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  function automatic void cmp_field(input string name, input logic [ADDR_W-1:0] want,
                                    input logic [ADDR_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // status monitor
  always @(posedge clk) begin : status_monitor
    out_item_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pairing_status_q.size() == 0) begin
          $display("%0t: unexpected status: expected none, actual phase %0d running %0b",
                   $time, out_ch.phase, out_ch.running);
          fail_count++;
        end else begin
          want = pairing_status_q.pop_front();
          cmp_field("tx_valid",   want.tx_valid,   out_ch.tx_valid);
          cmp_field("tx_kind",    want.tx_kind,    out_ch.tx_kind);
          cmp_field("addr_valid", want.addr_valid, out_ch.addr_valid);
          cmp_field("addr_value", want.addr_value, out_ch.addr_value);
          cmp_field("phase",      want.phase,      out_ch.phase);
          cmp_field("running",    want.running,    out_ch.running);
          cmp_field("verified",   want.verified,   out_ch.verified);
        end
      end
      out_ch.ready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off so the unit backs up and drops in_ch.ready
  initial begin : receiver_holdoff
    hold_on = 1'b0;
    wait (hold_go);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (80) @(posedge clk);
    hold_on <= 1'b0;
  end

  // settings writes, shadow copy follows
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_GLOBAL_TIMEOUT: pair_cfg.session_timeout_ms = val[TIME_W-1:0];
      CFG_RESP_WAIT:      pair_cfg.resp_wait_ms       = val[WAIT_W-1:0];
      CFG_VERIFY_TIMEOUT: pair_cfg.verify_timeout_ms  = val[WAIT_W-1:0];
      CFG_VERIFY_NEEDED:  pair_cfg.verify_needed      = val[CNT_W-1:0];
      CFG_OWN_MAGIC:      pair_cfg.own_magic          = val[MAGIC_W-1:0];
      CFG_PEER_MAGIC:     pair_cfg.peer_magic         = val[MAGIC_W-1:0];
      default:            pair_cfg.default_addr       = val[ADDR_W-1:0];
    endcase
  endtask

  task automatic cfg_load(input cfg_t c);
    cfg_write(CFG_GLOBAL_TIMEOUT, CFG_DATA_W'(c.session_timeout_ms));
    cfg_write(CFG_RESP_WAIT,      CFG_DATA_W'(c.resp_wait_ms));
    cfg_write(CFG_VERIFY_TIMEOUT, CFG_DATA_W'(c.verify_timeout_ms));
    cfg_write(CFG_VERIFY_NEEDED,  CFG_DATA_W'(c.verify_needed));
    cfg_write(CFG_OWN_MAGIC,      CFG_DATA_W'(c.own_magic));
    cfg_write(CFG_PEER_MAGIC,     CFG_DATA_W'(c.peer_magic));
    cfg_write(CFG_DEFAULT_ADDR,   CFG_DATA_W'(c.default_addr));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic cfg_t default_cfg();
    cfg_t c;
    c.session_timeout_ms = RST_GLOBAL_TIMEOUT;
    c.resp_wait_ms       = RST_RESP_WAIT;
    c.verify_timeout_ms  = RST_VERIFY_TIMEOUT;
    c.verify_needed      = RST_VERIFY_NEEDED;
    c.own_magic          = RST_OWN_MAGIC;
    c.peer_magic         = RST_PEER_MAGIC;
    c.default_addr       = RST_DEFAULT_ADDR;
    return c;
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.session_timeout_ms = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(30000, 5000);
    c.resp_wait_ms       = WAIT_W'($urandom_range(400));
    c.verify_timeout_ms  = WAIT_W'($urandom_range(3000, 50));
    c.verify_needed      = CNT_W'($urandom_range(8, 1));
    c.own_magic          = MAGIC_W'($urandom());
    c.peer_magic         = MAGIC_W'($urandom());
    c.default_addr       = ADDR_W'({$urandom(), $urandom()});
    return c;
  endfunction

  // one request at the current schedule time, packet of the chosen sort
  function automatic in_item_t make_req(input logic [CMD_W-1:0] cmd, input pkt_sel_t sel);
    in_item_t rq;
    rq.cmd       = cmd;
    rq.now_ms    = sched_ms;
    rq.rx_valid  = 1'b1;
    rq.rx_len_ok = 1'b1;
    rq.rx_kind   = KIND_W'($urandom_range(2));
    rq.rx_magic  = MAGIC_W'($urandom());
    rq.rx_addr   = ADDR_W'({$urandom(), $urandom()});
    case (sel)
      PKT_NONE: rq.rx_valid = 1'b0;
      PKT_RESP: rq.rx_kind = RX_RESP;
      PKT_PING: begin
        rq.rx_kind  = RX_PING;
        rq.rx_magic = pair_cfg.peer_magic;
      end
      default: begin
        rq.rx_valid  = 1'($urandom_range(1));
        rq.rx_len_ok = 1'($urandom_range(1));
      end
    endcase
    return rq;
  endfunction

  task automatic queue_req(input logic [CMD_W-1:0] cmd, input pkt_sel_t sel, input int junk_pct);
    sched_ms += TIME_W'($urandom_range(30));
    if ($urandom_range(99) < junk_pct) sel = PKT_JUNK;
    step_requests.push_back(make_req(cmd, sel));
  endtask

  task automatic queue_fixed(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] t,
                             input logic v, input logic ok, input logic [KIND_W-1:0] kind,
                             input logic [MAGIC_W-1:0] magic, input logic [ADDR_W-1:0] addr);
    step_requests.push_back(in_item_t'{cmd, t, v, ok, kind, magic, addr});
  endtask

  // a pairing session: start, request, response, pings, then the step after done
  task automatic add_session(input int junk_pct, input bit full_run);
    int n_pings;
    sched_ms = ($urandom_range(7) == 0) ? (32'hFFFF_FF00 | TIME_W'($urandom_range(255)))
                                        : $urandom();
    queue_req(CMD_START, PKT_NONE, junk_pct);
    queue_req(CMD_STEP, PKT_NONE, junk_pct);
    queue_req(CMD_STEP, PKT_NONE, junk_pct);
    // response lost, request goes out again
    if (junk_pct > 0 && $urandom_range(99) < 20) begin
      sched_ms += pair_cfg.resp_wait_ms + 1;
      queue_req(CMD_STEP, PKT_NONE, junk_pct);
      queue_req(CMD_STEP, PKT_NONE, junk_pct);
    end
    queue_req(CMD_STEP, PKT_RESP, junk_pct);
    n_pings = full_run ? pair_cfg.verify_needed + 1 : $urandom_range(pair_cfg.verify_needed + 1);
    repeat (n_pings) begin
      if (junk_pct > 0 && $urandom_range(99) < 4) sched_ms += pair_cfg.verify_timeout_ms + 1;
      if (junk_pct > 0 && $urandom_range(99) < 2) queue_req(CMD_STOP, PKT_JUNK, 0);
      queue_req(CMD_STEP, PKT_PING, junk_pct);
    end
    queue_req(CMD_STEP, PKT_NONE, junk_pct);
    if (junk_pct > 0 && $urandom_range(99) < 15)
      queue_req($urandom_range(1) ? CMD_STOP : CMD_UNUSED, PKT_JUNK, 0);
    if (junk_pct > 0 && $urandom_range(99) < 5) begin
      sched_ms += pair_cfg.session_timeout_ms + 1;
      queue_req(CMD_STEP, PKT_JUNK, 0);
    end
  endtask

  task automatic wait_drain();
    do @(negedge clk);
    while (step_requests.size() != 0 || in_ch.valid || pairing_status_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input cfg_t c, input int sidle, input int rstall, input int target,
                           input int junk_pct, input bit full_run, input bit pressure);
    cfg_load(c);
    @(negedge clk);
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    while (step_requests.size() < target) add_session(junk_pct, full_run);
    if (pressure) hold_go = 1'b1;
    wait_drain();
  endtask

  // stimulus and verdict
  initial begin : stimulus
    cfg_t c;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = CMD_STEP;
    in_ch.now_ms    = '0;
    in_ch.rx_valid  = 1'b0;
    in_ch.rx_len_ok = 1'b0;
    in_ch.rx_kind   = RX_OTHER;
    in_ch.rx_magic  = '0;
    in_ch.rx_addr   = '0;
    out_ch.ready    = 1'b0;
    on_bus          = '0;
    sched_ms        = '0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_go         = 1'b0;
    fail_count      = 0;
    pair_cfg        = default_cfg();
    pr_phase        = PH_CODE_IDLE;
    pr_active       = 1'b0;
    pr_global_start = '0;
    pr_wait_start   = '0;
    pr_pings        = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed walk through the phases, two pings needed
    c = default_cfg();
    c.verify_needed = 8'd2;
    cfg_load(c);
    @(negedge clk);
    queue_fixed(CMD_STEP,   32'd5,    1, 1, RX_PING,  8'hA5, 40'hFF_FFFF_FFFF); // not running
    queue_fixed(CMD_STOP,   32'd6,    0, 0, RX_OTHER, 8'h00, 40'h0);  // stop while not running
    queue_fixed(CMD_UNUSED, 32'd7,    1, 1, RX_RESP,  8'hFF, 40'h12_3456_789A);
    queue_fixed(CMD_START,  32'd100,  0, 0, RX_OTHER, 8'h00, 40'h0);
    queue_fixed(CMD_START,  32'd1000, 0, 0, RX_OTHER, 8'h00, 40'h0);  // restart while running
    queue_fixed(CMD_STEP,   32'd1001, 0, 0, RX_OTHER, 8'h00, 40'h0);
    queue_fixed(CMD_STEP,   32'd1002, 0, 0, RX_OTHER, 8'h00, 40'h0);  // request out
    queue_fixed(CMD_STEP,   32'd1003, 1, 1, RX_PING,  8'hA5, 40'h0);  // ping while waiting
    queue_fixed(CMD_STEP,   32'd1203, 0, 0, RX_OTHER, 8'h00, 40'h0);  // response timeout
    queue_fixed(CMD_STEP,   32'd1204, 0, 0, RX_OTHER, 8'h00, 40'h0);
    queue_fixed(CMD_STEP,   32'd1205, 1, 0, RX_RESP,  8'h00, 40'h55_5555_5555); // bad length
    queue_fixed(CMD_STEP,   32'd1405, 1, 1, RX_RESP,  8'h00, 40'hFF_FFFF_FFFF); // late but taken
    queue_fixed(CMD_STEP,   32'd1406, 1, 1, RX_PING,  8'h5A, 40'h0);  // wrong magic
    queue_fixed(CMD_STEP,   32'd1407, 0, 1, RX_PING,  8'hA5, 40'h0);  // no packet
    queue_fixed(CMD_STEP,   32'd1408, 1, 1, RX_PING,  8'hA5, 40'h0);
    queue_fixed(CMD_STEP,   32'd3406, 1, 1, RX_PING,  8'hA5, 40'h0);  // done, then timeout
    queue_fixed(CMD_STEP,   32'd3407, 0, 0, RX_OTHER, 8'h00, 40'h0);
    queue_fixed(CMD_STEP,   32'd3408, 1, 1, RX_RESP,  8'h00, 40'h0);
    queue_fixed(CMD_STEP,   32'd3409, 1, 1, RX_PING,  8'hA5, 40'h0);
    queue_fixed(CMD_STEP,   32'd3410, 1, 1, RX_PING,  8'hA5, 40'h0);  // done
    queue_fixed(CMD_STEP,   32'd3411, 1, 1, RX_PING,  8'hA5, 40'h0);  // leaves running
    queue_fixed(CMD_STOP,   32'd3412, 0, 0, RX_OTHER, 8'h00, 40'h0);
    queue_fixed(CMD_START,  32'hFFFF_FFF0, 0, 0, RX_OTHER, 8'h00, 40'h0);
    queue_fixed(CMD_STEP,   32'h0000_2700, 0, 0, RX_OTHER, 8'h00, 40'h0); // limit, wrapped
    queue_fixed(CMD_STEP,   32'h0000_2701, 0, 0, RX_OTHER, 8'h00, 40'h0); // global timeout
    queue_fixed(CMD_STOP,   32'h0000_2702, 0, 0, RX_OTHER, 8'h00, 40'h0);
    wait_drain();

    // random sessions under varied settings and flow control
    run_phase(default_cfg(), 0, 0, 180, 10, 1'b0, 1'b1);
    run_phase(random_cfg(), 47, 0, 150, 10, 1'b0, 1'b0);
    run_phase(random_cfg(), 0, 47, 150, 10, 1'b0, 1'b0);
    run_phase(random_cfg(), 26, 26, 150, 10, 1'b0, 1'b0);

    // smallest settings
    c = '0;
    c.verify_needed = 8'd1;
    run_phase(c, 26, 26, 40, 10, 1'b0, 1'b0);

    // largest settings, one long clean session up to the ping limit
    c.session_timeout_ms = '1;
    c.resp_wait_ms       = '1;
    c.verify_timeout_ms  = '1;
    c.verify_needed      = '1;
    c.own_magic          = '1;
    c.peer_magic         = '1;
    c.default_addr       = '1;
    run_phase(c, 0, 0, 250, 0, 1'b1, 1'b0);

    if (fail_count == 0 && pairing_status_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
